@@ rtl/rfbd_pkg.sv @@
`timescale 1ns / 1ps
package rfbd_pkg;

  localparam int PORT_DATA_BITS = 64;
  localparam int LIMIT_BITS     = 6;
  localparam int FILL_BITS      = 6;
  localparam int COUNT_BITS     = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic pop;
    logic empty_res;
  } cmd_t;

  typedef struct packed {
    logic can_pop;
    logic pop_last;
  } status_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

@@ rtl/rfbd_ram.sv @@
`timescale 1ns / 1ps
module rfbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rfbd_datapath.sv @@
`timescale 1ns / 1ps
module rfbd_datapath import rfbd_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   st,
  input  logic [PORT_DATA_BITS-1:0] span_data,
  input  logic [LIMIT_BITS-1:0]     drain_limit,
  output logic                      strobe,
  output logic [PORT_DATA_BITS-1:0] out_data,
  output logic                      out_valid,
  output logic                      last,
  output logic                      accepted,
  output logic [FILL_BITS-1:0]      fill_level,
  output logic [COUNT_BITS-1:0]     pushed_count,
  output logic [COUNT_BITS-1:0]     dropped_count,
  output logic [COUNT_BITS-1:0]     drained_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic [IW-1:0]         wr_idx;
  logic [IW-1:0]         rd_idx;
  logic [IW-1:0]         wr_idx_next;
  logic [IW-1:0]         rd_idx_next;
  logic [LIMIT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] pushed;
  logic [COUNT_BITS-1:0] dropped;
  logic [COUNT_BITS-1:0] drained;
  logic                  res_stb;
  logic                  res_valid;
  logic                  res_last;
  logic                  res_acc;
  logic                  full;
  logic                  empty;
  logic [FW-1:0]         diff;
  logic [FW-1:0]         fill_w;
  logic [DATA_BITS-1:0]  rdata;

  assign wr_idx_next = (wr_idx == LAST_IDX) ? '0 : wr_idx + IW'(1);
  assign rd_idx_next = (rd_idx == LAST_IDX) ? '0 : rd_idx + IW'(1);
  assign full        = (wr_idx_next == rd_idx);
  assign empty       = (wr_idx == rd_idx);

  assign st.can_pop  = (rem != '0) && !empty;
  assign st.pop_last = (rem == LIMIT_BITS'(1)) || (rd_idx_next == wr_idx);

  assign diff   = {1'b0, wr_idx} - {1'b0, rd_idx};
  assign fill_w = diff[FW-1] ? diff + FW'(DEPTH) : diff;

  rfbd_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push && !full),
    .waddr (wr_idx),
    .wdata (span_data[DATA_BITS-1:0]),
    .re    (cmd.pop),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx    <= '0;
      rd_idx    <= '0;
      rem       <= '0;
      pushed    <= '0;
      dropped   <= '0;
      drained   <= '0;
      res_stb   <= 1'b0;
      res_valid <= 1'b0;
      res_last  <= 1'b0;
      res_acc   <= 1'b0;
    end else begin
      res_stb <= cmd.push || cmd.pop || cmd.empty_res;
      if (cmd.push) begin
        res_valid <= 1'b0;
        res_last  <= 1'b1;
        res_acc   <= !full;
        if (full) begin
          dropped <= sat_inc(dropped);
        end else begin
          wr_idx <= wr_idx_next;
          pushed <= sat_inc(pushed);
        end
      end
      if (cmd.load) begin
        rem <= drain_limit;
      end
      if (cmd.pop) begin
        res_valid <= 1'b1;
        res_last  <= st.pop_last;
        res_acc   <= 1'b0;
        rd_idx    <= rd_idx_next;
        rem       <= rem - LIMIT_BITS'(1);
        drained   <= sat_inc(drained);
      end
      if (cmd.empty_res) begin
        res_valid <= 1'b0;
        res_last  <= 1'b1;
        res_acc   <= 1'b0;
      end
    end
  end

  assign strobe        = res_stb;
  assign out_valid     = res_valid;
  assign last          = res_last;
  assign accepted      = res_acc;
  assign out_data      = res_valid ? PORT_DATA_BITS'(rdata) : '0;
  assign fill_level    = FILL_BITS'(fill_w);
  assign pushed_count  = pushed;
  assign dropped_count = dropped;
  assign drained_count = drained;

  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> st.can_pop)
    else $error("pop issued with nothing to hand out");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_w <= FW'(DEPTH - 1))
    else $error("fill level beyond capacity");

  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.push && full |=> $stable(wr_idx))
    else $error("write index moved on a dropped push");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (drained == $past(drained) + COUNT_BITS'(1)) || ($past(drained) == COUNT_MAX))
    else $error("drained total did not advance");

  a_valid_stb: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stb |-> $past(cmd.pop))
    else $error("valid payload without a pop");

endmodule

@@ rtl/rfbd_ctrl.sv @@
`timescale 1ns / 1ps
module rfbd_ctrl import rfbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    mode,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        busy = 1'b1;
        if (st.can_pop) begin
          cmd.pop = 1'b1;
          if (st.pop_last) begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.empty_res = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ring_fifo_batch_drain.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     start & !busy            mode, span_data, drain_limit
// result    strobe (one cycle)       out_data, out_valid, last, accepted,
//                                    fill_level, pushed_count, dropped_count, drained_count
//
// A push's result shows on the cycle after start; busy stays low.
// A drain of n > 0 payloads holds busy high while it pops; results follow one per
// cycle from the RAM's registered read port, the first after the drain state's first pop.
// A drain that hands out nothing holds busy one cycle; its result is registered from the drain state.
// Reset is synchronous on rst and clears indices, totals and the controller.
// The receiver cannot stall; every result is taken in the cycle it is shown.
module ring_fifo_batch_drain import rfbd_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [PORT_DATA_BITS-1:0] span_data,
  input  logic [LIMIT_BITS-1:0]     drain_limit,
  output logic                      strobe,
  output logic [PORT_DATA_BITS-1:0] out_data,
  output logic                      out_valid,
  output logic                      last,
  output logic                      accepted,
  output logic [FILL_BITS-1:0]      fill_level,
  output logic [COUNT_BITS-1:0]     pushed_count,
  output logic [COUNT_BITS-1:0]     dropped_count,
  output logic [COUNT_BITS-1:0]     drained_count
);

  cmd_t    cmd;
  status_t st;

  rfbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  rfbd_datapath #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .span_data     (span_data),
    .drain_limit   (drain_limit),
    .strobe        (strobe),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .last          (last),
    .accepted      (accepted),
    .fill_level    (fill_level),
    .pushed_count  (pushed_count),
    .dropped_count (dropped_count),
    .drained_count (drained_count)
  );

endmodule

@@ verif/ring_fifo_batch_drain_checker.sv @@
`timescale 1ns / 1ps
module ring_fifo_batch_drain_checker import rfbd_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      mode,
  input  logic [PORT_DATA_BITS-1:0] span_data,
  input  logic [LIMIT_BITS-1:0]     drain_limit,
  input  logic                      strobe,
  input  logic [PORT_DATA_BITS-1:0] out_data,
  input  logic                      out_valid,
  input  logic                      last,
  input  logic                      accepted,
  input  logic [FILL_BITS-1:0]      fill_level,
  input  logic [COUNT_BITS-1:0]     pushed_count,
  input  logic [COUNT_BITS-1:0]     dropped_count,
  input  logic [COUNT_BITS-1:0]     drained_count,
  output int                        mismatches,
  output int                        results_due
);

  typedef struct packed {
    logic [PORT_DATA_BITS-1:0] data;
    logic                      valid;
    logic                      last;
    logic                      acc;
    logic [FILL_BITS-1:0]      fill;
    logic [COUNT_BITS-1:0]     pushed;
    logic [COUNT_BITS-1:0]     dropped;
    logic [COUNT_BITS-1:0]     drained;
  } fifo_result_t;

  localparam logic [PORT_DATA_BITS-1:0] DATA_MASK =
    {PORT_DATA_BITS{1'b1}} >> (PORT_DATA_BITS - DATA_BITS);

  logic [PORT_DATA_BITS-1:0] slots [DEPTH];
  int unsigned               wr_idx;
  int unsigned               rd_idx;
  logic [COUNT_BITS-1:0]     pushed_tot;
  logic [COUNT_BITS-1:0]     dropped_tot;
  logic [COUNT_BITS-1:0]     drained_tot;
  fifo_result_t              fifo_results_q [$];
  int                        err_count = 0;

  function automatic int unsigned wrap_next(input int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int unsigned stored_now();
    return (wr_idx + DEPTH - rd_idx) % DEPTH;
  endfunction

  function automatic fifo_result_t snapshot(input logic [PORT_DATA_BITS-1:0] d,
                                            input logic v, input logic l, input logic a);
    fifo_result_t r;
    r.data    = d & DATA_MASK;
    r.valid   = v;
    r.last    = l;
    r.acc     = a;
    r.fill    = FILL_BITS'(stored_now());
    r.pushed  = pushed_tot;
    r.dropped = dropped_tot;
    r.drained = drained_tot;
    return r;
  endfunction

  task automatic queue_result(input fifo_result_t r);
    fifo_results_q = {fifo_results_q, r};
  endtask

  task automatic apply_transaction(input logic m, input logic [PORT_DATA_BITS-1:0] d,
                                   input logic [LIMIT_BITS-1:0] lim);
    int unsigned take;
    int unsigned i;
    logic [PORT_DATA_BITS-1:0] popped;
    if (m == MODE_PUSH) begin
      if (wrap_next(wr_idx) == rd_idx) begin
        dropped_tot = bump(dropped_tot);
        queue_result(snapshot('0, 1'b0, 1'b1, 1'b0));
      end else begin
        slots[wr_idx] = d & DATA_MASK;
        wr_idx = wrap_next(wr_idx);
        pushed_tot = bump(pushed_tot);
        queue_result(snapshot('0, 1'b0, 1'b1, 1'b1));
      end
    end else begin
      take = (lim < stored_now()) ? lim : stored_now();
      if (take == 0) begin
        queue_result(snapshot('0, 1'b0, 1'b1, 1'b0));
      end
      for (i = 0; i < take; i++) begin
        popped = slots[rd_idx];
        rd_idx = wrap_next(rd_idx);
        drained_tot = bump(drained_tot);
        queue_result(snapshot(popped, 1'b1, i == take - 1, 1'b0));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [PORT_DATA_BITS-1:0] want,
                             input logic [PORT_DATA_BITS-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result();
    fifo_result_t want;
    if (fifo_results_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected transaction, expected none, actual out_data %0h last %b",
               $time, out_data, last);
    end else begin
      want = fifo_results_q.pop_front();
      check_field("out_data", want.data, out_data);
      check_field("out_valid", PORT_DATA_BITS'(want.valid), PORT_DATA_BITS'(out_valid));
      check_field("last", PORT_DATA_BITS'(want.last), PORT_DATA_BITS'(last));
      check_field("accepted", PORT_DATA_BITS'(want.acc), PORT_DATA_BITS'(accepted));
      check_field("fill_level", PORT_DATA_BITS'(want.fill), PORT_DATA_BITS'(fill_level));
      check_field("pushed_count", PORT_DATA_BITS'(want.pushed), PORT_DATA_BITS'(pushed_count));
      check_field("dropped_count", PORT_DATA_BITS'(want.dropped),
                  PORT_DATA_BITS'(dropped_count));
      check_field("drained_count", PORT_DATA_BITS'(want.drained),
                  PORT_DATA_BITS'(drained_count));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_idx      = 0;
      rd_idx      = 0;
      pushed_tot  = '0;
      dropped_tot = '0;
      drained_tot = '0;
      fifo_results_q.delete();
    end else begin
      if (strobe !== 1'b0) begin
        compare_result();
      end
      if (start && !busy) begin
        apply_transaction(mode, span_data, drain_limit);
      end
    end
    mismatches  <= err_count;
    results_due <= fifo_results_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench import rfbd_pkg::*; ;

  localparam int FIFO_DEPTH = 64;
  localparam int FIFO_BITS  = 64;
  localparam int ITEMS      = 230;
  localparam int QUIET_TAIL = 30;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      start       = 1'b0;
  logic                      mode        = MODE_PUSH;
  logic [PORT_DATA_BITS-1:0] span_data   = '0;
  logic [LIMIT_BITS-1:0]     drain_limit = '0;
  logic                      busy;
  logic                      strobe;
  logic [PORT_DATA_BITS-1:0] out_data;
  logic                      out_valid;
  logic                      last;
  logic                      accepted;
  logic [FILL_BITS-1:0]      fill_level;
  logic [COUNT_BITS-1:0]     pushed_count;
  logic [COUNT_BITS-1:0]     dropped_count;
  logic [COUNT_BITS-1:0]     drained_count;
  int                        mismatches;
  int                        results_due;
  int                        sent    = 0;
  bit                        idle_on = 1'b1;

  always #6 clk = ~clk;

  ring_fifo_batch_drain #(
    .DEPTH     (FIFO_DEPTH),
    .DATA_BITS (FIFO_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .span_data     (span_data),
    .drain_limit   (drain_limit),
    .strobe        (strobe),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .last          (last),
    .accepted      (accepted),
    .fill_level    (fill_level),
    .pushed_count  (pushed_count),
    .dropped_count (dropped_count),
    .drained_count (drained_count)
  );

  ring_fifo_batch_drain_checker #(
    .DEPTH     (FIFO_DEPTH),
    .DATA_BITS (FIFO_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .span_data     (span_data),
    .drain_limit   (drain_limit),
    .strobe        (strobe),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .last          (last),
    .accepted      (accepted),
    .fill_level    (fill_level),
    .pushed_count  (pushed_count),
    .dropped_count (dropped_count),
    .drained_count (drained_count),
    .mismatches    (mismatches),
    .results_due   (results_due)
  );

  task automatic issue(input logic m, input logic [PORT_DATA_BITS-1:0] d,
                       input logic [LIMIT_BITS-1:0] lim);
    if (idle_on && sent < ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    span_data   <= d;
    drain_limit <= lim;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    int k;
    int fills;
    int guard;
    fills = 0;
    guard = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(MODE_DRAIN, '1, 6'd0);
    issue(MODE_DRAIN, '0, 6'd63);
    issue(MODE_PUSH, 64'h0, 6'd63);
    issue(MODE_PUSH, '1, 6'd0);
    issue(MODE_PUSH, 64'h5555_5555_5555_5555, 6'h2A);
    issue(MODE_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 6'h15);
    issue(MODE_PUSH, 64'h8000_0000_0000_0001, 6'd0);
    issue(MODE_DRAIN, 64'h1234, 6'd0);
    issue(MODE_DRAIN, '1, 6'd1);
    issue(MODE_DRAIN, '0, 6'd2);
    issue(MODE_DRAIN, '0, 6'd63);
    issue(MODE_DRAIN, '0, 6'd5);
    issue(MODE_PUSH, 64'h0123_4567_89AB_CDEF, 6'd7);
    issue(MODE_PUSH, 64'hFEDC_BA98_7654_3210, 6'd56);
    issue(MODE_DRAIN, '0, 6'd2);

    while (sent < ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (fills < 2 && sent + FIFO_DEPTH + 3 <= ITEMS &&
          (fills == 0 || $urandom_range(0, 7) == 0)) begin
        // overfill so that pushes are dropped, then drain the ring (fully on the first pass)
        for (k = 0; k < FIFO_DEPTH + 2; k++) begin
          issue(MODE_PUSH, {$urandom, $urandom}, 6'($urandom));
        end
        issue(MODE_DRAIN, {$urandom, $urandom},
              (fills == 0) ? 6'd63 : 6'($urandom_range(30, 63)));
        fills++;
      end else begin
        case ($urandom_range(0, 9)) inside
          [0:4]: begin
            repeat ($urandom_range(1, 12)) issue(MODE_PUSH, {$urandom, $urandom}, 6'($urandom));
          end
          [5:8]: begin
            case ($urandom_range(0, 3))
              0:       issue(MODE_DRAIN, {$urandom, $urandom}, 6'd0);
              1:       issue(MODE_DRAIN, {$urandom, $urandom}, 6'd63);
              default: issue(MODE_DRAIN, {$urandom, $urandom}, 6'($urandom_range(1, 63)));
            endcase
          end
          default: begin
            issue(1'($urandom), {$urandom, $urandom}, 6'($urandom));
          end
        endcase
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rfbd_pkg.sv
rtl/rfbd_ram.sv
rtl/rfbd_datapath.sv
rtl/rfbd_ctrl.sv
rtl/ring_fifo_batch_drain.sv
verif/ring_fifo_batch_drain_checker.sv
verif/testbench.sv
